// ===== design/itsc_pkg.sv =====
// ----------------------------------------------------------------------------
// itsc_pkg: image transfer session checker package
// Packet kinds, session states, error codes, register indexes and the
// sequencer state type.
// ----------------------------------------------------------------------------
package itsc_pkg;

  // packet kinds
  localparam logic [1:0] MODE_START  = 2'd0;
  localparam logic [1:0] MODE_CHUNK  = 2'd1;
  localparam logic [1:0] MODE_COMMIT = 2'd2;
  localparam logic [1:0] MODE_RESET  = 2'd3;

  // configuration register indexes
  localparam logic CFG_MAX_WIDTH = 1'b0;
  localparam logic CFG_ENV_SIZE  = 1'b1;

  // reset values of the configuration registers
  localparam logic [11:0] MAX_WIDTH_RST = 12'd384;
  localparam logic [7:0]  ENV_SIZE_RST  = 8'd16;

  // error codes
  localparam logic [2:0] E_NONE       = 3'd0;
  localparam logic [2:0] E_STATE      = 3'd1;
  localparam logic [2:0] E_ENVELOPE   = 3'd2;
  localparam logic [2:0] E_TRANSFER   = 3'd3;
  localparam logic [2:0] E_SEQUENCE   = 3'd4;
  localparam logic [2:0] E_LENGTH     = 3'd5;
  localparam logic [2:0] E_OVERFLOW   = 3'd6;
  localparam logic [2:0] E_INCOMPLETE = 3'd7;

  // number of shift-add or restoring steps per operation
  localparam int          STEPS     = 16;
  localparam logic [3:0]  STEP_LAST = 4'(STEPS - 1);

  typedef enum logic [1:0] {
    SS_IDLE  = 2'd0,
    SS_RECV  = 2'd1,
    SS_READY = 2'd2,
    SS_ERROR = 2'd3
  } session_t;

  typedef enum logic [1:0] {
    SQ_IDLE,
    SQ_MUL,
    SQ_MOD,
    SQ_POST
  } seq_state_t;

endpackage

// ===== design/image_transfer_session_checker.sv =====
// ----------------------------------------------------------------------------
// image_transfer_session_checker: upload session checker
// Validates start, chunk, commit and reset packets of a packetized image
// upload and reports one status word per packet.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+------------------------------
//  packet   | in        | pkt_valid / pkt_stall | mode .. env_total_length
//  result   | out       | res_valid / res_stall | accepted .. expected_sequence
//  config   | in        | cfg_write             | cfg_index, cfg_data
//
// Sequence: a start or chunk word is taken in idle, runs 16 steps of the shared
//   33-bit adder, then a decision state; commit and reset go from idle straight
//   to the decision state. The steps are the shift-add multiply stride*height
//   for a start and the restoring remainder length%stride for a chunk.
// Reset: rst is synchronous, active high; clears the session and restores
//   max_image_width to 384 and envelope_size to 16.
// Stalls: pkt_stall is high while a word is in work. A finished result sits in
//   the output register; if that is still held by res_stall, the decision
//   cycle waits until it frees up.
//
module image_transfer_session_checker import itsc_pkg::*; #(
  parameter int BITS_PER_PIXEL = 1
) (
  input  logic        clk,
  input  logic        rst,
  // packet channel
  input  logic        pkt_valid,
  output logic        pkt_stall,
  input  logic [1:0]  mode,
  input  logic [31:0] transfer_id,
  input  logic [15:0] sequence_req,
  input  logic [15:0] header_length,
  input  logic [15:0] chunk_length,
  input  logic        payload_present,
  input  logic [15:0] env_width,
  input  logic [15:0] env_height,
  input  logic [15:0] env_stride,
  input  logic [31:0] env_total_length,
  // result channel
  output logic        res_valid,
  input  logic        res_stall,
  output logic        accepted,
  output logic [1:0]  session_state_out,
  output logic [2:0]  error_code,
  output logic [31:0] received_count,
  output logic [15:0] expected_sequence,
  // configuration
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [11:0] cfg_data
);

  // width of w*BITS_PER_PIXEL+7
  localparam int SUM_W = 16 + $clog2(BITS_PER_PIXEL) + 1;

  // configuration registers
  logic [11:0] max_image_width;
  logic [7:0]  envelope_size;

  // latched packet word
  logic [1:0]  p_mode;
  logic [31:0] p_tid;
  logic [15:0] p_seq;
  logic [15:0] p_hlen;
  logic [15:0] p_len;
  logic        p_present;
  logic [15:0] p_width;
  logic [15:0] p_height;
  logic [15:0] p_stride;
  logic [31:0] p_total;

  // session state
  session_t    ss, ss_next;
  logic [31:0] bytes_received, bytes_received_next;
  logic [31:0] active_transfer, active_transfer_next;
  logic [15:0] next_seq, next_seq_next;
  logic [2:0]  last_error, last_error_next;
  logic [31:0] stored_total, stored_total_next;
  logic [15:0] stored_stride, stored_stride_next;
  logic        ok;

  // sequencer and shared unit
  seq_state_t  seq, seq_next;
  logic [3:0]  cnt;
  logic [31:0] acc;     // product, or remainder in the low bits
  logic [15:0] sh;      // multiplier / dividend bits, MSB first
  logic [15:0] opnd;    // multiplicand / divisor
  logic [32:0] add_a, add_b, add_sum;
  logic        add_cin;

  logic        pkt_take;
  logic        post_go;

  assign pkt_stall = (seq != SQ_IDLE);
  assign pkt_take  = pkt_valid && !pkt_stall;
  assign post_go   = (seq == SQ_POST) && (!res_valid || !res_stall);

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      max_image_width <= MAX_WIDTH_RST;
      envelope_size   <= ENV_SIZE_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_MAX_WIDTH: max_image_width <= cfg_data;
        CFG_ENV_SIZE:  envelope_size   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      seq <= SQ_IDLE;
    end else begin
      seq <= seq_next;
    end
  end

  always_comb begin
    seq_next = seq;
    case (seq)
      SQ_IDLE: begin
        if (pkt_take) begin
          case (mode)
            MODE_START: seq_next = SQ_MUL;
            MODE_CHUNK: seq_next = SQ_MOD;
            default:    seq_next = SQ_POST;
          endcase
        end
      end
      SQ_MUL, SQ_MOD: begin
        if (cnt == STEP_LAST) begin
          seq_next = SQ_POST;
        end
      end
      SQ_POST: begin
        if (post_go) begin
          seq_next = SQ_IDLE;
        end
      end
      default: seq_next = SQ_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Shared adder: shift-add multiply step or restoring remainder step
  // --------------------------------------------------------------------------
  always_comb begin
    if (seq == SQ_MUL) begin
      add_a   = {1'b0, acc[30:0], 1'b0};
      add_b   = sh[15] ? {17'b0, opnd} : 33'b0;
      add_cin = 1'b0;
    end else begin
      add_a   = {16'b0, acc[15:0], sh[15]};
      add_b   = ~{17'b0, opnd};
      add_cin = 1'b1;
    end
    add_sum = add_a + add_b + {32'b0, add_cin};
  end

  always_ff @(posedge clk) begin
    if (pkt_take) begin
      p_mode    <= mode;
      p_tid     <= transfer_id;
      p_seq     <= sequence_req;
      p_hlen    <= header_length;
      p_len     <= chunk_length;
      p_present <= payload_present;
      p_width   <= env_width;
      p_height  <= env_height;
      p_stride  <= env_stride;
      p_total   <= env_total_length;
      acc       <= 32'b0;
      cnt       <= 4'b0;
      if (mode == MODE_START) begin
        sh   <= env_height;
        opnd <= env_stride;
      end else begin
        sh   <= chunk_length;
        opnd <= stored_stride;
      end
    end else if (seq == SQ_MUL || seq == SQ_MOD) begin
      cnt <= cnt + 4'd1;
      sh  <= {sh[14:0], 1'b0};
      if (seq == SQ_MUL) begin
        acc <= add_sum[31:0];
      end else if (!add_sum[32]) begin
        // trial subtract did not go negative: keep the difference
        acc <= {15'b0, add_sum[16:0]};
      end else begin
        acc <= {15'b0, acc[15:0], sh[15]};
      end
    end
  end

  // --------------------------------------------------------------------------
  // Decision: checks in the order state, transfer, sequence, length, then
  // overflow or completeness. A rejection only touches state and code.
  // --------------------------------------------------------------------------
  logic [SUM_W-1:0] stride_calc;
  logic             env_bad;
  logic [32:0]      br_sum;
  logic             hdr_state_bad, hdr_tid_bad, hdr_seq_bad;
  logic             len_bad;

  always_comb begin
    stride_calc = (SUM_W'(p_width) * SUM_W'(BITS_PER_PIXEL) + SUM_W'(7)) >> 3;
    // acc holds p_stride*p_height, equal to the expected total whenever the
    // stride matches
    env_bad = (p_hlen != {8'b0, envelope_size}) || (p_width == 16'b0) ||
              (p_height == 16'b0) || (p_width > {4'b0, max_image_width}) ||
              (p_total != acc) || (stride_calc != SUM_W'(p_stride));
    br_sum  = {1'b0, bytes_received} + {17'b0, p_len};

    hdr_state_bad = (ss != SS_RECV);
    hdr_tid_bad   = (p_tid != active_transfer);
    hdr_seq_bad   = (p_seq != next_seq);
    len_bad = (p_len != p_hlen) || !p_present || (p_len == 16'b0) ||
              (stored_stride == 16'b0) || (acc[16:0] != 17'b0);

    ss_next              = ss;
    bytes_received_next  = bytes_received;
    active_transfer_next = active_transfer;
    next_seq_next        = next_seq;
    last_error_next      = last_error;
    stored_total_next    = stored_total;
    stored_stride_next   = stored_stride;
    ok                   = 1'b0;

    case (p_mode)
      MODE_START: begin
        if (ss == SS_RECV || ss == SS_READY) begin
          last_error_next = E_STATE;
        end else if (env_bad) begin
          last_error_next = E_ENVELOPE;
        end else begin
          ok                   = 1'b1;
          stored_total_next    = p_total;
          stored_stride_next   = p_stride;
          bytes_received_next  = 32'b0;
          active_transfer_next = p_tid;
          next_seq_next        = p_seq + 16'd1;
          last_error_next      = E_NONE;
        end
      end
      MODE_CHUNK: begin
        if (hdr_state_bad) begin
          last_error_next = E_STATE;
        end else if (hdr_tid_bad) begin
          last_error_next = E_TRANSFER;
        end else if (hdr_seq_bad) begin
          last_error_next = E_SEQUENCE;
        end else if (len_bad) begin
          last_error_next = E_LENGTH;
        end else if (br_sum > {1'b0, stored_total}) begin
          last_error_next = E_OVERFLOW;
        end else begin
          ok                  = 1'b1;
          bytes_received_next = br_sum[31:0];
          next_seq_next       = next_seq + 16'd1;
          last_error_next     = E_NONE;
        end
      end
      MODE_COMMIT: begin
        if (hdr_state_bad) begin
          last_error_next = E_STATE;
        end else if (hdr_tid_bad) begin
          last_error_next = E_TRANSFER;
        end else if (hdr_seq_bad) begin
          last_error_next = E_SEQUENCE;
        end else if (bytes_received != stored_total) begin
          last_error_next = E_INCOMPLETE;
        end else begin
          ok              = 1'b1;
          last_error_next = E_NONE;
        end
      end
      default: begin
        // reset packet: back to a clean session
        ok                   = 1'b1;
        bytes_received_next  = 32'b0;
        active_transfer_next = 32'b0;
        next_seq_next        = 16'b0;
        last_error_next      = E_NONE;
        stored_total_next    = 32'b0;
        stored_stride_next   = 16'b0;
      end
    endcase

    if (p_mode == MODE_RESET) begin
      ss_next = SS_IDLE;
    end else if (!ok) begin
      ss_next = SS_ERROR;
    end else if (p_mode == MODE_START) begin
      ss_next = SS_RECV;
    end else if (p_mode == MODE_COMMIT) begin
      ss_next = SS_READY;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ss              <= SS_IDLE;
      bytes_received  <= 32'b0;
      active_transfer <= 32'b0;
      next_seq        <= 16'b0;
      last_error      <= E_NONE;
      stored_total    <= 32'b0;
      stored_stride   <= 16'b0;
    end else if (post_go) begin
      ss              <= ss_next;
      bytes_received  <= bytes_received_next;
      active_transfer <= active_transfer_next;
      next_seq        <= next_seq_next;
      last_error      <= last_error_next;
      stored_total    <= stored_total_next;
      stored_stride   <= stored_stride_next;
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (post_go) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (post_go) begin
      accepted          <= ok;
      session_state_out <= ss_next;
      error_code        <= last_error_next;
      received_count    <= bytes_received_next;
      expected_sequence <= next_seq_next;
    end
  end

`ifndef NO_ASSERTIONS
  // a new result only comes out of the decision cycle
  a_res_from_post: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(seq == SQ_POST))
    else $error("result appeared without a decision cycle");

  // a rejected word always leaves the session in error with a code
  a_reject_error: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !accepted) |-> (session_state_out == SS_ERROR &&
                                  error_code != E_NONE))
    else $error("rejection without error state");

  // an accepted word clears the error code
  a_accept_clean: assert property (@(posedge clk) disable iff (rst)
    (res_valid && accepted) |-> (error_code == E_NONE))
    else $error("accepted word with error code");

  // the shared unit stops after its last step
  a_step_end: assert property (@(posedge clk) disable iff (rst)
    ((seq == SQ_MUL || seq == SQ_MOD) && cnt == STEP_LAST) |=> (seq == SQ_POST))
    else $error("iteration did not end on the last step");
`endif

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: image_transfer_session_checker testbench
// A directed list of packet words checks the session rules: starts with bad
// envelopes, chunks with a wrong id, sequence or length, overflow, an early
// commit and a full upload. Random upload sessions then run under six
// register settings, with random idle bursts on both channels. Every status
// word is checked field by field against a typed status or an in-bench tracker.
// ----------------------------------------------------------------------------
module tb;
  import itsc_pkg::*;

  localparam int          PIXEL_BITS   = 1;
  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int          PHASES       = 6;
  localparam int          PHASE_WORDS  = 155;
  localparam logic [31:0] ID_A         = 32'h5A5A_A5A5;

  // one packet word as it sits on the input ports
  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] id;
    logic [15:0] seq;
    logic [15:0] hlen;
    logic [15:0] clen;
    logic        pres;
    logic [15:0] ew;
    logic [15:0] eh;
    logic [15:0] es;
    logic [31:0] et;
  } word_t;

  // one status word as it leaves the block
  typedef struct packed {
    logic        ok;
    session_t    st;
    logic [2:0]  err;
    logic [31:0] count;
    logic [15:0] seq;
  } status_t;

  // directed row: the word, and a hand-typed status where one is given
  typedef struct packed {
    word_t   w;
    logic    typed;
    status_t want;
  } row_t;

  logic        clk;
  logic        rst;
  logic        pkt_valid;
  logic        pkt_stall;
  logic [1:0]  mode;
  logic [31:0] transfer_id;
  logic [15:0] sequence_req;
  logic [15:0] header_length;
  logic [15:0] chunk_length;
  logic        payload_present;
  logic [15:0] env_width;
  logic [15:0] env_height;
  logic [15:0] env_stride;
  logic [31:0] env_total_length;
  logic        res_valid;
  logic        res_stall;
  logic        accepted;
  logic [1:0]  session_state_out;
  logic [2:0]  error_code;
  logic [31:0] received_count;
  logic [15:0] expected_sequence;
  logic        cfg_write;
  logic        cfg_index;
  logic [11:0] cfg_data;

  // session tracker: shadow of the block's state and registers
  session_t    sess;
  logic [31:0] got_bytes;
  logic [31:0] cur_id;
  logic [15:0] next_sq;
  logic [2:0]  last_err;
  logic [31:0] img_total;
  logic [15:0] img_stride;
  logic [11:0] lim_width;
  logic [7:0]  lim_env;

  status_t     pending[$];   // status words still owed by the block
  status_t     head;
  row_t        plan[$];
  int unsigned idle_pct;
  int unsigned phase_idle[PHASES] = '{25, 0, 40, 15, 30, 0};
  int unsigned cycle_count;
  int unsigned mismatches;
  int unsigned words_in;
  int unsigned words_out;
  int unsigned uploads;
  logic [7:0]  codes_seen;

  image_transfer_session_checker #(.BITS_PER_PIXEL(PIXEL_BITS)) uut (
    .clk               (clk),
    .rst               (rst),
    .pkt_valid         (pkt_valid),
    .pkt_stall         (pkt_stall),
    .mode              (mode),
    .transfer_id       (transfer_id),
    .sequence_req      (sequence_req),
    .header_length     (header_length),
    .chunk_length      (chunk_length),
    .payload_present   (payload_present),
    .env_width         (env_width),
    .env_height        (env_height),
    .env_stride        (env_stride),
    .env_total_length  (env_total_length),
    .res_valid         (res_valid),
    .res_stall         (res_stall),
    .accepted          (accepted),
    .session_state_out (session_state_out),
    .error_code        (error_code),
    .received_count    (received_count),
    .expected_sequence (expected_sequence),
    .cfg_write         (cfg_write),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Session tracker
  // --------------------------------------------------------------------------
  function automatic void clear_session();
    sess       = SS_IDLE;
    got_bytes  = '0;
    cur_id     = '0;
    next_sq    = '0;
    last_err   = E_NONE;
    img_total  = '0;
    img_stride = '0;
  endfunction

  // any rejection: only the state and the code move
  function automatic logic mark_fault(logic [2:0] code);
    last_err = code;
    sess     = SS_ERROR;
    return 1'b0;
  endfunction

  function automatic status_t track_session(word_t w);
    logic [63:0] row_bytes;
    logic [63:0] img_bytes;
    logic        ok;
    row_bytes = (64'(w.ew) * PIXEL_BITS + 64'd7) / 64'd8;
    img_bytes = row_bytes * 64'(w.eh);
    ok = 1'b1;
    case (w.mode)
      MODE_START: begin
        if (sess == SS_RECV || sess == SS_READY)
          ok = mark_fault(E_STATE);
        else if (w.hlen != 16'(lim_env) || w.ew == 0 || w.eh == 0 ||
                 w.ew > 16'(lim_width) || 64'(w.et) != img_bytes ||
                 64'(w.es) != row_bytes)
          ok = mark_fault(E_ENVELOPE);
        else begin
          sess       = SS_RECV;
          img_total  = w.et;
          img_stride = w.es;
          got_bytes  = '0;
          cur_id     = w.id;
          next_sq    = w.seq + 16'd1;
          last_err   = E_NONE;
        end
      end
      MODE_CHUNK: begin
        // order: state, id, sequence, length, overflow
        if (sess != SS_RECV)
          ok = mark_fault(E_STATE);
        else if (w.id != cur_id)
          ok = mark_fault(E_TRANSFER);
        else if (w.seq != next_sq)
          ok = mark_fault(E_SEQUENCE);
        else if (w.clen != w.hlen || !w.pres || w.clen == 0 || img_stride == 0 ||
                 (w.clen % img_stride) != 0)
          ok = mark_fault(E_LENGTH);
        else if (33'(got_bytes) + 33'(w.clen) > 33'(img_total))
          ok = mark_fault(E_OVERFLOW);
        else begin
          got_bytes = got_bytes + 32'(w.clen);
          next_sq   = next_sq + 16'd1;
          last_err  = E_NONE;
        end
      end
      MODE_COMMIT: begin
        if (sess != SS_RECV)
          ok = mark_fault(E_STATE);
        else if (w.id != cur_id)
          ok = mark_fault(E_TRANSFER);
        else if (w.seq != next_sq)
          ok = mark_fault(E_SEQUENCE);
        else if (got_bytes != img_total)
          ok = mark_fault(E_INCOMPLETE);
        else begin
          sess     = SS_READY;
          last_err = E_NONE;
        end
      end
      default: clear_session();
    endcase
    return '{ok, sess, last_err, got_bytes, next_sq};
  endfunction

  // --------------------------------------------------------------------------
  // Word builders
  // --------------------------------------------------------------------------
  function automatic word_t pk(logic [1:0] md, logic [31:0] id, logic [15:0] seq,
                               logic [15:0] hlen, logic [15:0] clen, logic pres,
                               logic [15:0] ew, logic [15:0] eh, logic [15:0] es,
                               logic [31:0] et);
    return '{md, id, seq, hlen, clen, pres, ew, eh, es, et};
  endfunction

  function automatic status_t st(logic ok, session_t s, logic [2:0] err,
                                 logic [31:0] count, logic [15:0] seq);
    return '{ok, s, err, count, seq};
  endfunction

  function automatic row_t row(word_t w, logic typed, status_t want);
    return '{w, typed, want};
  endfunction

  function automatic word_t noise_word();
    word_t w;
    w.mode = 2'($urandom);
    w.id   = $urandom;
    w.seq  = 16'($urandom);
    w.hlen = 16'($urandom);
    w.clen = 16'($urandom);
    w.pres = 1'($urandom);
    w.ew   = 16'($urandom);
    w.eh   = 16'($urandom);
    w.es   = 16'($urandom);
    w.et   = $urandom;
    return w;
  endfunction

  // consistent envelope for the current limits; mostly small images
  function automatic word_t good_start();
    word_t       w;
    int unsigned top;
    int unsigned wd;
    int unsigned ht;
    w = noise_word();
    w.mode = MODE_START;
    top = (lim_width == 0) ? 1 : lim_width;
    case ($urandom_range(0, 9))
      0: wd = top;
      1: wd = 1;
      default: wd = $urandom_range(1, (top < 64) ? top : 64);
    endcase
    ht = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 65535) : $urandom_range(1, 12);
    w.ew   = 16'(wd);
    w.eh   = 16'(ht);
    w.es   = 16'((wd * PIXEL_BITS + 7) / 8);
    w.et   = 32'(w.es) * 32'(ht);
    w.hlen = 16'(lim_env);
    return w;
  endfunction

  function automatic word_t bad_start();
    word_t w;
    w = good_start();
    case ($urandom_range(0, 5))
      0: w.hlen = w.hlen + 16'($urandom_range(1, 65535));
      1: w.ew = '0;
      2: w.eh = '0;
      3: w.ew = 16'(lim_width) + 16'($urandom_range(1, 65535 - lim_width));
      4: w.es = w.es + 16'($urandom_range(1, 65535));
      default: w.et = w.et + $urandom_range(1, 1000);
    endcase
    return w;
  endfunction

  // legal chunk; often the largest that fits so uploads finish
  function automatic word_t good_chunk();
    word_t       w;
    int unsigned room;
    int unsigned most;
    int unsigned k;
    w = noise_word();
    w.mode = MODE_CHUNK;
    w.id   = cur_id;
    w.seq  = next_sq;
    w.pres = 1'b1;
    room = (img_total - got_bytes) / img_stride;
    most = 65535 / img_stride;
    if (room < most)
      most = room;
    if (most == 0)
      k = 1;
    else if ($urandom_range(0, 9) < 4)
      k = most;
    else
      k = $urandom_range(1, most);
    w.clen = 16'(k * img_stride);
    w.hlen = w.clen;
    return w;
  endfunction

  function automatic word_t bad_chunk();
    word_t       w;
    int unsigned over;
    w = good_chunk();
    case ($urandom_range(0, 6))
      0: w.id = w.id ^ (32'd1 << $urandom_range(0, 31));
      1: w.seq = w.seq + 16'($urandom_range(1, 65535));
      2: w.hlen = w.hlen ^ (16'd1 << $urandom_range(0, 15));
      3: w.pres = 1'b0;
      4: begin
        w.clen = '0;
        w.hlen = '0;
      end
      5: if (img_stride > 1) begin
        w.clen = w.clen - 16'($urandom_range(1, img_stride - 1));
        w.hlen = w.clen;
      end
      default: begin
        // one stride past what is left
        over = ((img_total - got_bytes) / img_stride + 1) * img_stride;
        if (over <= 65535) begin
          w.clen = 16'(over);
          w.hlen = w.clen;
        end
      end
    endcase
    return w;
  endfunction

  function automatic word_t commit_word();
    word_t w;
    w = noise_word();
    w.mode = MODE_COMMIT;
    w.id   = cur_id;
    w.seq  = next_sq;
    case ($urandom_range(0, 9))
      0: w.id = w.id ^ (32'd1 << $urandom_range(0, 31));
      1: w.seq = w.seq + 16'($urandom_range(1, 65535));
      default: ;
    endcase
    return w;
  endfunction

  // mostly well-formed sessions, some broken words and pure noise
  function automatic word_t draw_word();
    word_t       w;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (sess != SS_RECV) begin
      if (pick < 60)
        w = good_start();
      else if (pick < 78)
        w = bad_start();
      else if (pick < 88) begin
        w = noise_word();
        w.mode = MODE_RESET;
      end else
        w = noise_word();
    end else if (got_bytes == img_total && pick < 55)
      w = commit_word();
    else if (pick < 58)
      w = good_chunk();
    else if (pick < 68)
      w = commit_word();
    else if (pick < 84)
      w = bad_chunk();
    else if (pick < 89)
      w = good_start();
    else if (pick < 93) begin
      w = noise_word();
      w.mode = MODE_RESET;
    end else
      w = noise_word();
    return w;
  endfunction

  // --------------------------------------------------------------------------
  // Packet and config drivers (change on the falling edge)
  // --------------------------------------------------------------------------
  task automatic send_word(word_t w, logic typed, status_t want);
    status_t model;
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      @(negedge clk);
      pkt_valid <= 1'b0;
      repeat ($urandom_range(0, 13)) @(negedge clk);
    end
    @(negedge clk);
    pkt_valid        <= 1'b1;
    mode             <= w.mode;
    transfer_id      <= w.id;
    sequence_req     <= w.seq;
    header_length    <= w.hlen;
    chunk_length     <= w.clen;
    payload_present  <= w.pres;
    env_width        <= w.ew;
    env_height       <= w.eh;
    env_stride       <= w.es;
    env_total_length <= w.et;
    @(posedge clk);
    while (pkt_stall) @(posedge clk);
    model = track_session(w);
    pending.push_back(typed ? want : model);
    words_in++;
    codes_seen[model.err] = 1'b1;
    if (w.mode == MODE_COMMIT && model.ok)
      uploads++;
  endtask

  // hold the packet side until every owed status word is back
  task automatic drain_results();
    @(negedge clk);
    pkt_valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
  endtask

  task automatic set_limits(logic [11:0] width_cap, logic [7:0] env_len);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= CFG_MAX_WIDTH;
    cfg_data  <= width_cap;
    @(negedge clk);
    cfg_index <= CFG_ENV_SIZE;
    cfg_data  <= {4'($urandom), env_len};   // upper bits are junk, not stored
    @(negedge clk);
    cfg_write <= 1'b0;
    lim_width = width_cap;
    lim_env   = env_len;
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stall bursts, check on the rising edge
  // --------------------------------------------------------------------------
  initial begin : stall_gen
    int unsigned hold;
    hold = 0;
    res_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold != 0) begin
        res_stall <= 1'b1;
        hold--;
      end else begin
        res_stall <= 1'b0;
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct / 2)
          hold = $urandom_range(1, 14);
      end
    end
  end

  task automatic note_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    $display("[%0t] mismatch on %s: got %0h, want %0h", $time, what, got, want);
  endtask

  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      words_out++;
      if (pending.size() == 0)
        note_mismatch("status word with nothing owed", received_count, '0);
      else begin
        head = pending.pop_front();
        if (accepted !== head.ok)
          note_mismatch("accepted", 32'(accepted), 32'(head.ok));
        if (session_state_out !== head.st)
          note_mismatch("session_state_out", 32'(session_state_out), 32'(head.st));
        if (error_code !== head.err)
          note_mismatch("error_code", 32'(error_code), 32'(head.err));
        if (received_count !== head.count)
          note_mismatch("received_count", received_count, head.count);
        if (expected_sequence !== head.seq)
          note_mismatch("expected_sequence", 32'(expected_sequence), 32'(head.seq));
      end
    end
  end

  // watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d status words owed", cycle_count, pending.size());
    $display("** image_transfer_session_checker: FAILED **");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst              = 1'b1;
    pkt_valid        = 1'b0;
    mode             = MODE_RESET;
    transfer_id      = '0;
    sequence_req     = '0;
    header_length    = '0;
    chunk_length     = '0;
    payload_present  = 1'b0;
    env_width        = '0;
    env_height       = '0;
    env_stride       = '0;
    env_total_length = '0;
    cfg_write        = 1'b0;
    cfg_index        = CFG_MAX_WIDTH;
    cfg_data         = '0;
    mismatches       = 0;
    words_in         = 0;
    words_out        = 0;
    uploads          = 0;
    codes_seen       = '0;
    idle_pct         = 20;
    lim_width        = MAX_WIDTH_RST;
    lim_env          = ENV_SIZE_RST;
    clear_session();

    // Directed words at the reset limits (width 384, envelope 16). Session
    // A: 17 px wide, 4 rows, so stride 3 and total 12; next sequence 0x1235.
    plan.push_back(row(pk(MODE_CHUNK, 0, 0, 0, 0, 0, 0, 0, 0, 0),
                       1'b1, st(1'b0, SS_ERROR, E_STATE, 0, 0)));
    plan.push_back(row(pk(MODE_COMMIT, 0, 0, 0, 0, 0, 0, 0, 0, 0),
                       1'b1, st(1'b0, SS_ERROR, E_STATE, 0, 0)));
    // reset with every field at all ones
    plan.push_back(row(pk(MODE_RESET, '1, '1, '1, '1, 1'b1, '1, '1, '1, '1),
                       1'b1, st(1'b1, SS_IDLE, E_NONE, 0, 0)));
    // bad envelopes: header length, zero width, zero height, too wide, max all
    plan.push_back(row(pk(MODE_START, 1, 0, 15, 0, 1'b1, 384, 2, 48, 96),
                       1'b1, st(1'b0, SS_ERROR, E_ENVELOPE, 0, 0)));
    plan.push_back(row(pk(MODE_START, 1, 0, 16, 0, 1'b1, 0, 2, 0, 0),
                       1'b1, st(1'b0, SS_ERROR, E_ENVELOPE, 0, 0)));
    plan.push_back(row(pk(MODE_START, 1, 0, 16, 0, 1'b1, 8, 0, 1, 0),
                       1'b1, st(1'b0, SS_ERROR, E_ENVELOPE, 0, 0)));
    plan.push_back(row(pk(MODE_START, 1, 0, 16, 0, 1'b1, 385, 1, 49, 49),
                       1'b1, st(1'b0, SS_ERROR, E_ENVELOPE, 0, 0)));
    plan.push_back(row(pk(MODE_START, 1, 0, 16, 0, 1'b1, 16'hFFFF, 16'hFFFF, 8192,
                          32'd536862720),
                       1'b1, st(1'b0, SS_ERROR, E_ENVELOPE, 0, 0)));
    // widest legal start; sequence wraps to zero
    plan.push_back(row(pk(MODE_START, '1, 16'hFFFF, 16, 0, 1'b0, 384, 2, 48, 96),
                       1'b1, st(1'b1, SS_RECV, E_NONE, 0, 0)));
    // start while receiving
    plan.push_back(row(pk(MODE_START, 2, 0, 16, 0, 1'b0, 8, 1, 1, 1),
                       1'b1, st(1'b0, SS_ERROR, E_STATE, 0, 0)));
    plan.push_back(row(pk(MODE_START, ID_A, 16'h1234, 16, 0, 1'b0, 17, 4, 3, 12),
                       1'b1, st(1'b1, SS_RECV, E_NONE, 0, 16'h1235)));
    plan.push_back(row(pk(MODE_CHUNK, ID_A ^ 32'd1, 16'h1235, 3, 3, 1'b1, 0, 0, 0, 0),
                       1'b1, st(1'b0, SS_ERROR, E_TRANSFER, 0, 16'h1235)));
    plan.push_back(row(pk(MODE_START, ID_A, 16'h1234, 16, 0, 1'b0, 17, 4, 3, 12),
                       1'b1, st(1'b1, SS_RECV, E_NONE, 0, 16'h1235)));
    plan.push_back(row(pk(MODE_CHUNK, ID_A, 16'h1236, 3, 3, 1'b1, 0, 0, 0, 0),
                       1'b1, st(1'b0, SS_ERROR, E_SEQUENCE, 0, 16'h1235)));
    plan.push_back(row(pk(MODE_START, ID_A, 16'h1234, 16, 0, 1'b0, 17, 4, 3, 12),
                       1'b0, '0));
    // half the image, then an early commit
    plan.push_back(row(pk(MODE_CHUNK, ID_A, 16'h1235, 6, 6, 1'b1, 0, 0, 0, 0), 1'b0, '0));
    plan.push_back(row(pk(MODE_COMMIT, ID_A, 16'h1236, 0, 0, 1'b0, 0, 0, 0, 0), 1'b0, '0));
    plan.push_back(row(pk(MODE_START, ID_A, 16'h1234, 16, 0, 1'b0, 17, 4, 3, 12),
                       1'b0, '0));
    // payload buffer missing
    plan.push_back(row(pk(MODE_CHUNK, ID_A, 16'h1235, 12, 12, 1'b0, 0, 0, 0, 0),
                       1'b1, st(1'b0, SS_ERROR, E_LENGTH, 0, 16'h1235)));
    plan.push_back(row(pk(MODE_START, ID_A, 16'h1234, 16, 0, 1'b0, 17, 4, 3, 12),
                       1'b0, '0));
    // not a multiple of the stride
    plan.push_back(row(pk(MODE_CHUNK, ID_A, 16'h1235, 4, 4, 1'b1, 0, 0, 0, 0),
                       1'b1, st(1'b0, SS_ERROR, E_LENGTH, 0, 16'h1235)));
    plan.push_back(row(pk(MODE_START, ID_A, 16'h1234, 16, 0, 1'b0, 17, 4, 3, 12),
                       1'b0, '0));
    // one stride past the total
    plan.push_back(row(pk(MODE_CHUNK, ID_A, 16'h1235, 15, 15, 1'b1, 0, 0, 0, 0),
                       1'b1, st(1'b0, SS_ERROR, E_OVERFLOW, 0, 16'h1235)));
    plan.push_back(row(pk(MODE_START, ID_A, 16'h1234, 16, 0, 1'b0, 17, 4, 3, 12),
                       1'b0, '0));
    // whole image in one chunk, commit, then a start while ready
    plan.push_back(row(pk(MODE_CHUNK, ID_A, 16'h1235, 12, 12, 1'b1, 0, 0, 0, 0), 1'b0, '0));
    plan.push_back(row(pk(MODE_COMMIT, ID_A, 16'h1236, 0, 0, 1'b0, 0, 0, 0, 0), 1'b0, '0));
    plan.push_back(row(pk(MODE_START, 7, 0, 16, 0, 1'b0, 8, 1, 1, 1), 1'b0, '0));

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i])
      send_word(plan[i].w, plan[i].typed, plan[i].want);

    // Random sessions under each register setting; the block must be idle
    // before a register write, so each phase starts with a full drain.
    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      case (p)
        0: set_limits(12'd4095, 8'd255);
        1: set_limits(12'd1, 8'd1);
        2: set_limits(12'd0, 8'd0);     // every start is refused
        4: set_limits(MAX_WIDTH_RST, ENV_SIZE_RST);
        default: set_limits(12'($urandom_range(1, 4095)), 8'($urandom));
      endcase
      idle_pct = phase_idle[p];        // last phase runs without idling
      for (int i = 0; i < PHASE_WORDS; i++) begin
        if ($urandom_range(0, 199) == 0)
          drain_results();
        send_word(draw_word(), 1'b0, '0);
      end
    end

    drain_results();
    repeat (40) @(posedge clk);

    $display("covered %0d packet words, %0d status words, %0d uploads committed",
             words_in, words_out, uploads);
    $display("error codes raised (bit per code): %b, mismatches: %0d",
             codes_seen, mismatches);
    if (mismatches == 0)
      $display("** image_transfer_session_checker: PASSED **");
    else
      $display("** image_transfer_session_checker: FAILED **");
    $finish;
  end

endmodule
